FILE: hdl/tlc_pkg.sv
package tlc_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 8;
    localparam int PIN_FIELD_W = 14;
    localparam int PIN_NUM_W   = 4;
    localparam int IDX_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 4;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_MAP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_FIRST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_SECOND  = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_ARM  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_TRACING = 2'd2
    } t_run_state;

    // where the read word of a result comes from
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_HELD = 2'd1,
        RD_MEM  = 2'd2
    } t_rd_src;

endpackage

FILE: hdl/triggered_logic_capture.sv
// Logic analyzer capture engine. Accepts one word per clock cycle while the output is not
// stalled and returns one result word per input word, via the stage and output registers.
// The rate is set by the sample store: one read, one write per cycle, registered read data.
// The two newest waiting samples (entries 0 and 1) live in registers. Entries 2 and up live in
// the memory. An arm command clears the store at once, with no clearing pass: a fill count
// marks which memory entries were written since the arm. The rest read as zero.
module triggered_logic_capture
    import tlc_pkg::*;
#(
    parameter int STORE_DEPTH = 256,
    parameter int MAX_TRACES  = 8,
    parameter int PIN_COUNT   = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin_levels[13:0], read_index[21:14], zero pad
    input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd[1:0]
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // run_status[1:0], read_data[9:2], zero pad
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int WP_W = $clog2(STORE_DEPTH + 1);
    localparam int XW   = (AW > IDX_W) ? AW : IDX_W;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pin_map;
    logic [COUNT_W-1:0]    r_trace_count;
    logic [SAMPLE_W-1:0]   r_trig_mask;
    logic [SAMPLE_W-1:0]   r_trig_first;
    logic [SAMPLE_W-1:0]   r_trig_second;

    // capture state
    t_run_state          r_state, n_state;
    logic                r_first, n_first;
    logic [WP_W-1:0]     r_wp, n_wp;
    logic [SAMPLE_W-1:0] r_e0, n_e0;
    logic [SAMPLE_W-1:0] r_e1, n_e1;

    // sample memory
    logic [SAMPLE_W-1:0] r_store [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       rd_addr;

    // stage after acceptance
    logic                r_s1_valid;
    t_run_state          r_s1_status, n_s1_status;
    t_rd_src             r_s1_src, n_s1_src;
    logic [SAMPLE_W-1:0] r_s1_held, n_s1_held;

    // output register
    logic                r_out_valid;
    t_run_state          r_out_status;
    logic [SAMPLE_W-1:0] r_out_data;

    logic                accept;
    logic                advance;
    t_cmd                cmd;
    logic [PIN_FIELD_W-1:0] pins;
    logic [IDX_W-1:0]    rd_idx;
    logic [XW-1:0]       rd_idx_x;
    logic [15:0]         levels;
    logic [SAMPLE_W-1:0] sample;
    logic [WP_W-1:0]     wp_inc;

    assign cmd      = t_cmd'(s_axis_tuser);
    assign pins     = s_axis_tdata[PIN_FIELD_W-1:0];
    assign rd_idx   = s_axis_tdata[PIN_FIELD_W+IDX_W-1:PIN_FIELD_W];
    assign rd_idx_x = XW'(rd_idx);
    assign rd_addr  = rd_idx_x[AW-1:0];
    assign levels   = 16'(pins);
    assign wp_inc   = r_wp + 1'b1;

    // handshake: the output register frees the stage, the stage frees the input
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_re        = accept && (cmd == CMD_READ);

    // gather trace bits through the pin map
    always_comb begin
        logic [PIN_NUM_W-1:0] pin;
        sample = '0;
        for (int k = 0; k < MAX_TRACES; k++) begin
            pin = r_pin_map[PIN_NUM_W*k +: PIN_NUM_W];
            if (k < int'(r_trace_count) && int'(pin) < PIN_COUNT) begin
                sample[k] = levels[pin];
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_map     <= '0;
            r_trace_count <= '0;
            r_trig_mask   <= '0;
            r_trig_first  <= '0;
            r_trig_second <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PIN_MAP:     r_pin_map     <= i_cfg_data;
                CFG_TRACE_COUNT: r_trace_count <= i_cfg_data[COUNT_W-1:0];
                CFG_TRIG_MASK:   r_trig_mask   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TRIG_FIRST:  r_trig_first  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TRIG_SECOND: r_trig_second <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state and store access for an accepted word
    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_wp     = r_wp;
        n_e0     = r_e0;
        n_e1     = r_e1;
        mem_we   = 1'b0;
        n_s1_src  = RD_ZERO;
        n_s1_held = '0;
        if (accept) begin
            case (cmd)
                CMD_TICK: begin
                    case (r_state)
                        ST_WAITING: begin
                            n_e0 = r_e1;
                            n_e1 = sample;
                            if (r_first) begin
                                n_first = 1'b0;
                            end else if (r_trig_first == (r_trig_mask & r_e1) &&
                                         r_trig_second == (r_trig_mask & sample)) begin
                                n_state = ST_TRACING;
                            end
                        end
                        ST_TRACING: begin
                            mem_we = 1'b1;
                            n_wp   = wp_inc;
                            if (wp_inc >= WP_W'(STORE_DEPTH)) begin
                                n_state = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_ARM: begin
                    n_e0    = '0;
                    n_e1    = '0;
                    n_wp    = WP_W'(2);
                    n_first = 1'b1;
                    n_state = ST_WAITING;
                end
                CMD_READ: begin
                    // entries past the fill count were cleared by the last arm
                    if (rd_idx < IDX_W'(2)) begin
                        n_s1_src  = RD_HELD;
                        n_s1_held = rd_idx[0] ? r_e1 : r_e0;
                    end else if (int'(rd_idx) < int'(r_wp)) begin
                        n_s1_src = RD_MEM;
                    end
                end
                default: ;
            endcase
        end
        n_s1_status = n_state;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DONE;
            r_first     <= 1'b0;
            r_wp        <= '0;
            r_e0        <= '0;
            r_e1        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_wp    <= n_wp;
            r_e0    <= n_e0;
            r_e1    <= n_e1;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // sample memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wp[AW-1:0]] <= sample;
        end
        if (mem_re) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // stage and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_src    <= n_s1_src;
            r_s1_held   <= n_s1_held;
        end
        if (advance && r_s1_valid) begin
            r_out_status <= r_s1_status;
            case (r_s1_src)
                RD_HELD: r_out_data <= r_s1_held;
                RD_MEM:  r_out_data <= r_rd_data;
                default: r_out_data <= '0;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_data, r_out_status});

endmodule

FILE: hdl/tlc_checker.sv
module tlc_checker
    import tlc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // status is one of the three run states
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad run status code");

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

endmodule

bind triggered_logic_capture tlc_checker u_tlc_checker (.*);

FILE: verif/tb_triggered_logic_capture.sv
module tb_triggered_logic_capture;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    localparam int DEPTH       = 256;
    localparam int N_TRACES    = 8;
    localparam int N_PINS      = 14;
    localparam int ITEM_TARGET = 1550;
    localparam int BURST_LEN   = 250;

    // command code the block does not define, and register slots past the list
    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [PIN_FIELD_W-1:0] pins;
        logic [IDX_W-1:0]       ridx;
    } cap_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] data;
    } cap_result_t;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // pin_levels[13:0], read_index[21:14], zero pad
    logic [CMD_W-1:0]      s_axis_tuser = '0;   // cmd[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // run_status[1:0], read_data[9:2], zero pad

    // stimulus and scoreboard
    cap_word_t   stim_words[$];
    cap_result_t pending_results[$];
    int          words_queued = 0;
    int          mismatch_cnt = 0;
    bit          in_taken = 1'b0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    bit          burst_go = 1'b0;
    bit          burst_done = 1'b0;
    int          burst_left = 0;

    // capture engine shadow state
    logic [31:0]         pin_map;
    logic [COUNT_W-1:0]  trc_count;
    logic [SAMPLE_W-1:0] trig_mask;
    logic [SAMPLE_W-1:0] trig_first;
    logic [SAMPLE_W-1:0] trig_second;
    t_run_state          run_st;
    bit                  first_pending;
    int                  wr_pos;
    logic [SAMPLE_W-1:0] cap_mem [DEPTH];

    triggered_logic_capture i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // trace bits gathered from the pins through the pin map
    function automatic logic [SAMPLE_W-1:0] trace_sample(logic [PIN_FIELD_W-1:0] pins);
        logic [SAMPLE_W-1:0] s;
        logic [3:0]          pin;
        int                  n;
        s = '0;
        n = (trc_count > N_TRACES) ? N_TRACES : int'(trc_count);
        for (int k = 0; k < n; k++) begin
            pin = pin_map[4*k +: 4];
            if (pin < N_PINS) s[k] = pins[pin];
        end
        return s;
    endfunction

    // advances the shadow engine by one word and gives the result it reports
    function automatic cap_result_t predict_capture(cap_word_t w);
        cap_result_t r;
        r.data = '0;
        case (w.cmd)
            CMD_TICK: begin
                if (run_st == ST_WAITING) begin
                    cap_mem[0] = cap_mem[1];
                    cap_mem[1] = trace_sample(w.pins);
                    if (first_pending) begin
                        first_pending = 1'b0;
                    end else if ((trig_mask & cap_mem[0]) == trig_first &&
                                 (trig_mask & cap_mem[1]) == trig_second) begin
                        run_st = ST_TRACING;
                    end
                end else if (run_st == ST_TRACING) begin
                    if (wr_pos < DEPTH) cap_mem[wr_pos] = cap_mem[wr_pos] | trace_sample(w.pins);
                    wr_pos++;
                    if (wr_pos >= DEPTH) run_st = ST_DONE;
                end
            end
            CMD_ARM: begin
                foreach (cap_mem[i]) cap_mem[i] = '0;
                wr_pos = 2;
                first_pending = 1'b1;
                run_st = ST_WAITING;
            end
            CMD_READ: begin
                r.data = cap_mem[w.ridx];
            end
            default: ;
        endcase
        r.status = run_st;
        return r;
    endfunction

    // pin levels that make the mapped traces show the wanted sample where they can
    function automatic logic [PIN_FIELD_W-1:0] pins_for(logic [SAMPLE_W-1:0] want);
        logic [PIN_FIELD_W-1:0] p;
        logic [3:0]             pin;
        int                     n;
        p = PIN_FIELD_W'($urandom_range(0, 16383));
        n = (trc_count > N_TRACES) ? N_TRACES : int'(trc_count);
        for (int k = 0; k < n; k++) begin
            pin = pin_map[4*k +: 4];
            if (pin < N_PINS) p[pin] = want[k];
        end
        return p;
    endfunction

    function automatic logic [PIN_FIELD_W-1:0] rand_pins();
        return PIN_FIELD_W'($urandom_range(0, 16383));
    endfunction

    // reads lean toward the low entries where captures land
    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 255));
    endfunction

    task automatic push_word(logic [CMD_W-1:0] cmd, logic [PIN_FIELD_W-1:0] pins,
                             logic [IDX_W-1:0] ridx);
        cap_word_t w;
        w.cmd = cmd;
        w.pins = pins;
        w.ridx = ridx;
        stim_words.push_back(w);
        if (cmd != CMD_UNUSED) words_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PIN_MAP:     pin_map = val;
            CFG_TRACE_COUNT: trc_count = val[COUNT_W-1:0];
            CFG_TRIG_MASK:   trig_mask = val[SAMPLE_W-1:0];
            CFG_TRIG_FIRST:  trig_first = val[SAMPLE_W-1:0];
            CFG_TRIG_SECOND: trig_second = val[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    // nothing queued, nothing in flight
    task automatic wait_quiet();
        while (stim_words.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_random_setup();
        logic [31:0]         pmap;
        logic [SAMPLE_W-1:0] m;
        logic [SAMPLE_W-1:0] f;
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 7))
            0:       pmap = 32'h0000_0000;
            1:       pmap = 32'hFFFF_FFFF;
            2:       pmap = 32'h7654_3210;
            default: pmap = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0:       m = 8'h00;
            1:       m = 8'hFF;
            default: m = 8'($urandom_range(0, 255));
        endcase
        // mostly levels inside the mask, sometimes stray bits that block the trigger
        f = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : (8'($urandom()) & m);
        s = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : (8'($urandom()) & m);
        write_reg(CFG_PIN_MAP, pmap);
        write_reg(CFG_TRACE_COUNT, ($urandom_range(0, 1) == 0) ? 32'd8 : $urandom_range(0, 15));
        write_reg(CFG_TRIG_MASK, {24'h0, m});
        write_reg(CFG_TRIG_FIRST, {24'h0, f});
        write_reg(CFG_TRIG_SECOND, {24'h0, s});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom());
    endtask

    // arm, wait, trigger, trace, read back; now and then plain noise
    task automatic queue_sequence(bit full_run);
        int n_trace;
        if (!full_run && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(4, 12))
                push_word(CMD_W'($urandom_range(0, 3)), rand_pins(),
                          IDX_W'($urandom_range(0, 255)));
            return;
        end
        push_word(CMD_ARM, rand_pins(), rand_idx());
        repeat ($urandom_range(0, 4)) push_word(CMD_TICK, rand_pins(), rand_idx());
        push_word(CMD_TICK, pins_for(trig_first), rand_idx());
        push_word(CMD_TICK, pins_for(trig_second), rand_idx());
        if (full_run || $urandom_range(0, 15) == 0) n_trace = DEPTH + 4;
        else n_trace = $urandom_range(4, 40);
        repeat (n_trace) begin
            if ($urandom_range(0, 6) == 0) push_word(CMD_READ, rand_pins(), rand_idx());
            else if ($urandom_range(0, 60) == 0) push_word(CMD_ARM, rand_pins(), rand_idx());
            else push_word(CMD_TICK, rand_pins(), rand_idx());
        end
        repeat ($urandom_range(2, 8)) push_word(CMD_READ, rand_pins(), rand_idx());
    endtask

    // word driver
    always @(negedge i_clk) begin : drive
        cap_word_t w;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (stim_words.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                w = stim_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {2'b00, w.ridx, w.pins};
                s_axis_tuser <= w.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (burst_go && !burst_done) begin
            burst_left = BURST_LEN;
            burst_done = 1'b1;
        end
        if (burst_left > 0) begin
            m_axis_tready <= 1'b0;
            burst_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // predict on accepted input words, check accepted result words
    always @(posedge i_clk) begin : monitor
        cap_word_t   w;
        cap_result_t exp_r;
        logic [STATUS_W-1:0] got_status;
        logic [SAMPLE_W-1:0] got_data;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            w.cmd = s_axis_tuser;
            w.pins = s_axis_tdata[PIN_FIELD_W-1:0];
            w.ridx = s_axis_tdata[PIN_FIELD_W +: IDX_W];
            pending_results.push_back(predict_capture(w));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = m_axis_tdata[STATUS_W-1:0];
            got_data = m_axis_tdata[STATUS_W +: SAMPLE_W];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: run_status %0d read_data 0x%02h",
                       got_status, got_data);
                mismatch_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got_status != exp_r.status) begin
                    $error("run_status expected %0d actual %0d", exp_r.status, got_status);
                    mismatch_cnt++;
                end
                if (got_data != exp_r.data) begin
                    $error("read_data expected 0x%02h actual 0x%02h", exp_r.data, got_data);
                    mismatch_cnt++;
                end
            end
        end
    end

    int src_idle_plan [5] = '{0, 54, 0, 32, 0};
    int snk_stall_plan [5] = '{0, 0, 54, 32, 0};

    initial begin
        int goal;
        pin_map = '0;
        trc_count = '0;
        trig_mask = '0;
        trig_first = '0;
        trig_second = '0;
        run_st = ST_DONE;
        first_pending = 1'b0;
        wr_pos = 0;
        foreach (cap_mem[i]) cap_mem[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: tick while done, unused command, trigger on all-zero levels
        push_word(CMD_TICK, 14'h3FFF, 8'hFF);
        push_word(CMD_READ, 14'h0000, 8'hFF);
        push_word(CMD_UNUSED, 14'h3FFF, 8'hFF);
        push_word(CMD_ARM, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        push_word(CMD_READ, 14'h0000, 8'h02);
        wait_quiet();

        // count above the maximum, a pin past the last one, rising edge trigger
        write_reg(CFG_PIN_MAP, 32'hEDCB_A910);
        write_reg(CFG_TRACE_COUNT, 32'hF);
        write_reg(CFG_TRIG_MASK, 32'hFF);
        write_reg(CFG_TRIG_FIRST, 32'h00);
        write_reg(CFG_TRIG_SECOND, 32'h7F);
        write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
        push_word(CMD_ARM, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        // re-arm in the middle of a trace
        push_word(CMD_ARM, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        push_word(CMD_TICK, 14'h3FFF, 8'h00);
        push_word(CMD_READ, 14'h0000, 8'h01);
        push_word(CMD_READ, 14'h3FFF, 8'h00);
        wait_quiet();

        // level bit outside the mask: never triggers
        write_reg(CFG_PIN_MAP, 32'h7654_3210);
        write_reg(CFG_TRACE_COUNT, 32'd8);
        write_reg(CFG_TRIG_MASK, 32'h0F);
        write_reg(CFG_TRIG_FIRST, 32'h10);
        write_reg(CFG_TRIG_SECOND, 32'h00);
        push_word(CMD_ARM, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h0000, 8'h00);
        push_word(CMD_TICK, 14'h0000, 8'h00);
        push_word(CMD_READ, 14'h0000, 8'h01);

        // random phases with different idling; the last one fills the store under a stall
        for (int ph = 0; ph < 5; ph++) begin
            goal = (ph == 4) ? ITEM_TARGET : words_queued + 300;
            src_idle_pct = src_idle_plan[ph];
            snk_stall_pct = snk_stall_plan[ph];
            if (ph == 4) begin
                wait_quiet();
                write_reg(CFG_PIN_MAP, 32'h7654_3210);
                write_reg(CFG_TRACE_COUNT, 32'd8);
                write_reg(CFG_TRIG_MASK, 32'h00);
                write_reg(CFG_TRIG_FIRST, 32'h00);
                write_reg(CFG_TRIG_SECOND, 32'h00);
                queue_sequence(1'b1);
                burst_go = 1'b1;
            end
            while (words_queued < goal) begin
                wait_quiet();
                load_random_setup();
                repeat (4) queue_sequence(1'b0);
            end
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tlc_pkg.sv
hdl/triggered_logic_capture.sv
hdl/tlc_checker.sv
verif/tb_triggered_logic_capture.sv
